// ===== sv/assert_macros.svh =====
// assertion macros used by the top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mcbch_pkg.sv =====
// types, constants and helper functions of the marker code encoder
package mcbch_pkg;

	localparam logic [2:0] MODE_HAMMING63 = 3'd0;
	localparam logic [2:0] MODE_PARITY65  = 3'd1;
	localparam logic [2:0] MODE_BCH13_9   = 3'd2;
	localparam logic [2:0] MODE_BCH13_5   = 3'd3;
	localparam logic [2:0] MODE_BCH22_12  = 3'd4;
	localparam logic [2:0] MODE_BCH22_7   = 3'd5;
	localparam logic [2:0] MODE_GLOBAL_ID = 3'd6;
	localparam logic [2:0] MODE_RAW       = 3'd7;

	localparam logic [2:0] CODE_MODE_RST = MODE_HAMMING63;
	localparam logic [3:0] RAW_SIDE_RST  = 4'd3;

	localparam int unsigned CW_W  = 61;
	localparam int unsigned LEN_W = 6;
	localparam int unsigned VAL_W = 64;

	// register indexes on the apb port
	localparam logic REG_CODE_MODE = 1'b0;
	localparam logic REG_RAW_SIDE  = 1'b1;

	// generator polynomials, bit i is the coefficient of x^i
	localparam logic [15:0] GEN_13_9  = 16'h0013;
	localparam logic [15:0] GEN_13_5  = 16'h01D1;
	localparam logic [15:0] GEN_22_12 = 16'h0769;
	localparam logic [15:0] GEN_22_7  = 16'h8FAF;

	localparam logic [5:0] HAMMING_TBL [8] = '{
		6'd0, 6'd7, 6'd25, 6'd30, 6'd42, 6'd45, 6'd51, 6'd52
	};

	localparam logic [5:0] PARITY_TBL [32] = '{
		6'd0, 6'd33, 6'd34, 6'd3, 6'd36, 6'd5, 6'd6, 6'd39,
		6'd40, 6'd9, 6'd10, 6'd43, 6'd12, 6'd45, 6'd46, 6'd15,
		6'd48, 6'd17, 6'd18, 6'd51, 6'd20, 6'd53, 6'd54, 6'd23,
		6'd24, 6'd57, 6'd58, 6'd27, 6'd60, 6'd29, 6'd30, 6'd63
	};

	typedef struct packed {
		logic [2:0] code_mode;
		logic [3:0] raw_side;
	} cfg_t;

	// parity column of data bit i: x^(r+i) mod g(x), evaluated at elaboration
	function automatic logic [15:0] bch_col(input int unsigned r, input logic [15:0] gen,
		input int unsigned i);
		logic [16:0] rem;
		int unsigned s;
		rem = 17'd1;
		for (s = 0; s < 32; s++) begin
			if (s < r + i) begin
				rem = rem << 1;
				if (rem[r]) begin
					rem = rem ^ {1'b0, gen};
				end
			end
		end
		return rem[15:0];
	endfunction

	// raw mode length side*side-3, zero when the side gives no usable length
	function automatic logic [5:0] raw_len(input logic [3:0] side);
		logic [5:0] len;
		case (side)
			4'd2:    len = 6'd1;
			4'd3:    len = 6'd6;
			4'd4:    len = 6'd13;
			4'd5:    len = 6'd22;
			4'd6:    len = 6'd33;
			4'd7:    len = 6'd46;
			4'd8:    len = 6'd61;
			default: len = 6'd0;
		endcase
		return len;
	endfunction

endpackage

// ===== sv/mcbch_cfg.sv =====
// apb configuration registers of the marker code encoder
module mcbch_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output mcbch_pkg::cfg_t    cfg
);
	import mcbch_pkg::*;

	logic [2:0] code_mode_q;
	logic [3:0] raw_side_q;
	logic       wr_en;
	logic       reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_mode_q <= CODE_MODE_RST;
			raw_side_q  <= RAW_SIDE_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_CODE_MODE: code_mode_q <= pwdata[2:0];
				REG_RAW_SIDE:  raw_side_q  <= pwdata[3:0];
				default:       code_mode_q <= code_mode_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_CODE_MODE: prdata = {29'd0, code_mode_q};
			REG_RAW_SIDE:  prdata = {28'd0, raw_side_q};
			default:       prdata = 32'd0;
		endcase
	end

	assign cfg.code_mode = code_mode_q;
	assign cfg.raw_side  = raw_side_q;

endmodule

// ===== sv/mcbch_enc.sv =====
// combinational codeword and length for one code value
module mcbch_enc (
	input  mcbch_pkg::cfg_t   cfg,
	input  logic [63:0]       value,
	output logic [60:0]       codeword,
	output logic [5:0]        code_length
);
	import mcbch_pkg::*;

	localparam int unsigned R13_9  = 4;
	localparam int unsigned K13_9  = 9;
	localparam int unsigned R13_5  = 8;
	localparam int unsigned K13_5  = 5;
	localparam int unsigned R22_12 = 10;
	localparam int unsigned K22_12 = 12;
	localparam int unsigned R22_7  = 15;
	localparam int unsigned K22_7  = 7;

	logic [R13_9-1:0]  t13_9  [K13_9];
	logic [R13_5-1:0]  t13_5  [K13_5];
	logic [R22_12-1:0] t22_12 [K22_12];
	logic [R22_7-1:0]  t22_7  [K22_7];

	logic [R13_9-1:0]  p13_9;
	logic [R13_5-1:0]  p13_5;
	logic [R22_12-1:0] p22_12;
	logic [R22_7-1:0]  p22_7;

	logic [5:0]  rlen;
	logic [63:0] rmask;
	logic        hi_zero;

	// each data bit contributes a fixed parity column
	for (genvar i = 0; i < K13_9; i++) begin : g_c13_9
		localparam logic [15:0] C = bch_col(R13_9, GEN_13_9, i);
		assign t13_9[i] = value[i] ? C[R13_9-1:0] : '0;
	end
	for (genvar i = 0; i < K13_5; i++) begin : g_c13_5
		localparam logic [15:0] C = bch_col(R13_5, GEN_13_5, i);
		assign t13_5[i] = value[i] ? C[R13_5-1:0] : '0;
	end
	for (genvar i = 0; i < K22_12; i++) begin : g_c22_12
		localparam logic [15:0] C = bch_col(R22_12, GEN_22_12, i);
		assign t22_12[i] = value[i] ? C[R22_12-1:0] : '0;
	end
	for (genvar i = 0; i < K22_7; i++) begin : g_c22_7
		localparam logic [15:0] C = bch_col(R22_7, GEN_22_7, i);
		assign t22_7[i] = value[i] ? C[R22_7-1:0] : '0;
	end

	always_comb begin
		p13_9  = '0;
		p13_5  = '0;
		p22_12 = '0;
		p22_7  = '0;
		for (int i = 0; i < K13_9; i++) p13_9 = p13_9 ^ t13_9[i];
		for (int i = 0; i < K13_5; i++) p13_5 = p13_5 ^ t13_5[i];
		for (int i = 0; i < K22_12; i++) p22_12 = p22_12 ^ t22_12[i];
		for (int i = 0; i < K22_7; i++) p22_7 = p22_7 ^ t22_7[i];
	end

	assign rlen    = raw_len(cfg.raw_side);
	assign rmask   = (64'd1 << rlen) - 64'd1;
	assign hi_zero = ((value & ~rmask) == 64'd0);

	always_comb begin
		codeword    = '0;
		code_length = '0;
		case (cfg.code_mode)
			MODE_HAMMING63: begin
				if (value[63:3] == '0) begin
					codeword    = 61'(HAMMING_TBL[value[2:0]]);
					code_length = 6'd6;
				end
			end
			MODE_PARITY65: begin
				if (value[63:5] == '0) begin
					codeword    = 61'(PARITY_TBL[value[4:0]]);
					code_length = 6'd6;
				end
			end
			MODE_BCH13_9: begin
				if (value[63:K13_9] == '0) begin
					codeword    = 61'({value[K13_9-1:0], p13_9});
					code_length = 6'd13;
				end
			end
			MODE_BCH13_5: begin
				if (value[63:K13_5] == '0) begin
					codeword    = 61'({value[K13_5-1:0], p13_5});
					code_length = 6'd13;
				end
			end
			MODE_BCH22_12: begin
				if (value[63:K22_12] == '0) begin
					codeword    = 61'({value[K22_12-1:0], p22_12});
					code_length = 6'd22;
				end
			end
			MODE_BCH22_7: begin
				if (value[63:K22_7] == '0) begin
					codeword    = 61'({value[K22_7-1:0], p22_7});
					code_length = 6'd22;
				end
			end
			MODE_GLOBAL_ID: begin
				codeword    = '0;
				code_length = '0;
			end
			MODE_RAW: begin
				if (rlen != 6'd0 && hi_zero) begin
					codeword    = value[60:0];
					code_length = rlen;
				end
			end
			default: begin
				codeword    = '0;
				code_length = '0;
			end
		endcase
	end

endmodule

// ===== sv/marker_code_bch_encoder_top.sv =====
// an accepted item goes to the input register, its result to the result register
// throughput: one item per cycle while out_stall is low, set by the single
// encode stage between the input register and the result register
// a stalled output holds its result; only an empty input register takes an item
// reset: arst_n clears both valid flags, code_mode to 0 and raw_side to 3
module marker_code_bch_encoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] code_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [60:0] codeword,
	output logic [5:0]  code_length,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mcbch_pkg::*;
	`include "assert_macros.svh"

	cfg_t        cfg;
	logic        valid_s1;
	logic [63:0] value_s1;
	logic        valid_s2;
	logic [60:0] codeword_s2;
	logic [5:0]  length_s2;
	logic [60:0] enc_cw;
	logic [5:0]  enc_len;
	logic        adv1;
	logic        adv2;

	mcbch_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mcbch_enc u_enc (
		.cfg         (cfg),
		.value       (value_s1),
		.codeword    (enc_cw),
		.code_length (enc_len)
	);

	// each stage moves when the one after it has room
	assign adv2     = !valid_s2 || !out_stall;
	assign adv1     = !valid_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= in_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			value_s1 <= code_value;
		end
		if (adv2 && valid_s1) begin
			codeword_s2 <= enc_cw;
			length_s2   <= enc_len;
		end
	end

	assign out_valid   = valid_s2;
	assign codeword    = codeword_s2;
	assign code_length = length_s2;

	`ASSERT_NEXT(a_accept_fills_s1, in_valid && !in_stall, valid_s1, "accepted item lost")
	`ASSERT_IMPL(a_empty_no_stall, !valid_s1, !in_stall, "stall with empty input stage")
	`ASSERT_IMPL(a_reject_zero, valid_s2 && length_s2 == 6'd0, codeword_s2 == 61'd0,
		"rejected item with nonzero codeword")
	`ASSERT_IMPL(a_len_legal, valid_s2, length_s2 == 6'd0 || length_s2 == 6'd1 ||
		length_s2 == 6'd6 || length_s2 == 6'd13 || length_s2 == 6'd22 ||
		length_s2 == 6'd33 || length_s2 == 6'd46 || length_s2 == 6'd61,
		"illegal code length")

endmodule

// ===== bench/marker_code_bch_encoder_top_tb.sv =====
// self-checking bench for the marker code encoder: modes, raw sides, idling and stalls
`timescale 1ns / 1ps

module marker_code_bch_encoder_top_tb;
	import mcbch_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SEG_ITEMS   = 75;

	// hamming codeword table, entry i at bits 6*i+5..6*i
	localparam logic [47:0] HAMMING_WORDS = {6'd52, 6'd51, 6'd45, 6'd42,
		6'd30, 6'd25, 6'd7, 6'd0};
	localparam logic [15:0] POLY_13_9  = 16'h0013;
	localparam logic [15:0] POLY_13_5  = 16'h01D1;
	localparam logic [15:0] POLY_22_12 = 16'h0769;
	localparam logic [15:0] POLY_22_7  = 16'h8FAF;

	typedef struct packed {
		logic [60:0] codeword;
		logic [5:0]  code_length;
	} marker_word_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] code_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [60:0] codeword;
	logic [5:0]  code_length;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	logic [63:0]  value_queue[$];
	marker_word_t codeword_queue[$];
	logic [2:0]   cfg_mode = CODE_MODE_RST;
	logic [3:0]   cfg_side = RAW_SIDE_RST;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	int           mismatch_count = 0;
	int           cycle_count = 0;
	bit           item_taken = 1'b0;

	marker_code_bch_encoder_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.code_value(code_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.codeword(codeword),
		.code_length(code_length),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// systematic bch: data above, remainder of data*x^r mod gen below
	function automatic logic [60:0] bch_systematic(input int n, input int k,
		input logic [15:0] gen, input logic [63:0] data);
		logic [63:0] shifted;
		logic [63:0] rem;
		int r;
		int b;
		r = n - k;
		shifted = data << r;
		rem = shifted;
		for (b = n - 1; b >= r; b--) begin
			if (rem[b]) begin
				rem = rem ^ ({48'd0, gen} << (b - r));
			end
		end
		rem = rem & ((64'd1 << r) - 64'd1);
		return 61'(shifted | rem);
	endfunction

	// number of data bits the setting accepts, -1 when every value is rejected
	function automatic int value_bits(input logic [2:0] mode, input logic [3:0] side);
		int sq;
		case (mode)
			MODE_HAMMING63: return 3;
			MODE_PARITY65:  return 5;
			MODE_BCH13_9:   return 9;
			MODE_BCH13_5:   return 5;
			MODE_BCH22_12:  return 12;
			MODE_BCH22_7:   return 7;
			MODE_GLOBAL_ID: return -1;
			default: begin
				sq = side * side;
				if (sq >= 4 && sq - 3 <= 61) begin
					return sq - 3;
				end
				return -1;
			end
		endcase
	endfunction

	function automatic marker_word_t encode_marker(input logic [2:0] mode,
		input logic [3:0] side, input logic [63:0] v);
		marker_word_t w;
		int bits;
		w = '0;
		bits = value_bits(mode, side);
		if (bits > 0 && v < (64'd1 << bits)) begin
			case (mode)
				MODE_HAMMING63: begin
					w.codeword = 61'(HAMMING_WORDS[v[2:0] * 6 +: 6]);
					w.code_length = 6'd6;
				end
				MODE_PARITY65: begin
					// odd data weight sets the top bit
					w.codeword = 61'({^v[4:0], v[4:0]});
					w.code_length = 6'd6;
				end
				MODE_BCH13_9: begin
					w.codeword = bch_systematic(13, 9, POLY_13_9, v);
					w.code_length = 6'd13;
				end
				MODE_BCH13_5: begin
					w.codeword = bch_systematic(13, 5, POLY_13_5, v);
					w.code_length = 6'd13;
				end
				MODE_BCH22_12: begin
					w.codeword = bch_systematic(22, 12, POLY_22_12, v);
					w.code_length = 6'd22;
				end
				MODE_BCH22_7: begin
					w.codeword = bch_systematic(22, 7, POLY_22_7, v);
					w.code_length = 6'd22;
				end
				default: begin
					w.codeword = v[60:0];
					w.code_length = 6'(bits);
				end
			endcase
		end
		return w;
	endfunction

	function automatic logic [63:0] pick_value(input int bits);
		logic [63:0] full;
		int sel;
		full = {$urandom, $urandom};
		sel = $urandom_range(0, 99);
		if (bits <= 0 || sel >= 85) begin
			return full;
		end
		if (sel >= 70) begin
			case (sel % 4)
				0: return (64'd1 << bits) - 64'd1;
				1: return 64'd1 << bits;
				2: return '0;
				default: return (64'd1 << bits) + (full & 64'hff);
			endcase
		end
		return full & ((64'd1 << bits) - 64'd1);
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(input logic [2:0] mode, input logic [3:0] side);
		apb_write({REG_CODE_MODE, 2'b00}, {29'd0, mode});
		apb_write({REG_RAW_SIDE, 2'b00}, {28'd0, side});
		cfg_mode = mode;
		cfg_side = side;
	endtask

	// sender holds off until every item has come back out
	task automatic drain;
		while (value_queue.size() != 0 || in_valid || codeword_queue.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic push_edges(input logic [2:0] mode, input logic [3:0] side);
		int bits;
		bits = value_bits(mode, side);
		if (bits > 0) begin
			value_queue.push_back((64'd1 << bits) - 64'd1);
			value_queue.push_back(64'd1 << bits);
		end else begin
			value_queue.push_back('0);
			value_queue.push_back('1);
		end
	endtask

	task automatic run_segment(input int seg, input logic [2:0] mode, input logic [3:0] side);
		int i;
		case (seg % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
			default: begin send_idle_pct = 8; recv_stall_pct = 8; end
		endcase
		set_config(mode, side);
		for (i = 0; i < SEG_ITEMS; i++) begin
			value_queue.push_back(pick_value(value_bits(mode, side)));
		end
		drain();
	endtask

	// driver
	always @(negedge clk) begin
		if (!in_valid || item_taken) begin
			if (value_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				code_value <= value_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
		item_taken = 1'b0;
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// monitor
	always @(posedge clk) begin
		marker_word_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				codeword_queue.push_back(encode_marker(cfg_mode, cfg_side, code_value));
				item_taken = 1'b1;
			end
			if (out_valid && !out_stall) begin
				if (codeword_queue.size() == 0) begin
					flag_mismatch("result with no item pending", 64'(codeword), '0);
				end else begin
					want = codeword_queue.pop_front();
					if (codeword !== want.codeword) begin
						flag_mismatch("codeword", 64'(codeword), 64'(want.codeword));
					end
					if (code_length !== want.code_length) begin
						flag_mismatch("code_length", 64'(code_length), 64'(want.code_length));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int seg;
		logic [3:0] bad_sides[$];
		bad_sides = '{4'd0, 4'd1, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15};
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// reset settings first, then the range edges of every mode
		value_queue.push_back(64'd0);
		value_queue.push_back(64'd7);
		value_queue.push_back(64'd8);
		value_queue.push_back('1);
		drain();
		for (int m = 1; m <= 6; m++) begin
			set_config(3'(m), 4'($urandom_range(0, 15)));
			push_edges(3'(m), cfg_side);
			drain();
		end
		set_config(MODE_RAW, 4'd8);
		push_edges(MODE_RAW, 4'd8);
		drain();
		set_config(MODE_RAW, 4'd2);
		push_edges(MODE_RAW, 4'd2);
		drain();
		set_config(MODE_RAW, 4'd0);
		value_queue.push_back('0);
		drain();
		set_config(MODE_RAW, 4'd15);
		value_queue.push_back('0);
		drain();

		seg = 0;
		for (int m = 0; m <= 6; m++) begin
			run_segment(seg++, 3'(m), 4'($urandom_range(0, 15)));
		end
		for (int s = 2; s <= 8; s++) begin
			run_segment(seg++, MODE_RAW, 4'(s));
		end
		repeat (2) begin
			run_segment(seg++, MODE_RAW, bad_sides[$urandom_range(0, bad_sides.size() - 1)]);
		end
		repeat (2) begin
			run_segment(seg++, 3'($urandom_range(0, 7)), 4'($urandom_range(2, 8)));
		end

		drain();
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
